/* rtl/core/bna_pkg.sv */
// ----------------------------------------------------------------------------
// bna_pkg
// Types, codes, constants and helpers shared by the batch-norm blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package bna_pkg;

   localparam int unsigned DATA_W = 16;
   localparam int unsigned PCH_W  = 6;
   localparam int unsigned CIU_W  = 7;
   localparam int unsigned MODE_W = 2;

   localparam logic [CIU_W-1:0] CIU_RESET = 7'd64;

   typedef enum logic [MODE_W-1:0] {
      ACT_NONE    = 2'd0,
      ACT_RELU    = 2'd1,
      ACT_TANH    = 2'd2,
      ACT_SIGMOID = 2'd3
   } act_mode_type;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef enum logic {
      REG_CIU  = 1'b0,
      REG_MODE = 1'b1
   } reg_index_type;

   typedef struct packed {
      op_type                    op;
      logic [PCH_W-1:0]          param_channel;
      logic signed [DATA_W-1:0]  channel_mean;
      logic [DATA_W-1:0]         channel_variance;
      logic signed [DATA_W-1:0]  channel_gamma;
      logic signed [DATA_W-1:0]  channel_beta;
      logic signed [DATA_W-1:0]  sample_value;
      logic                      row_end;
   } item_type;

   typedef struct packed {
      logic                      start;
      logic                      sigmoid;
      logic signed [DATA_W-1:0]  value;
   } act_req_type;

   typedef struct packed {
      logic                      done;
      logic signed [DATA_W-1:0]  value;
   } act_rsp_type;

   // exp(-1/256) series with a 60-bit fraction, truncated term by term
   localparam logic [63:0] ONE60 = 64'd1 << 60;
   localparam logic [63:0] ET1  = ONE60 / 64'd256;
   localparam logic [63:0] ET2  = ET1 / 64'd512;
   localparam logic [63:0] ET3  = ET2 / 64'd768;
   localparam logic [63:0] ET4  = ET3 / 64'd1024;
   localparam logic [63:0] ET5  = ET4 / 64'd1280;
   localparam logic [63:0] ET6  = ET5 / 64'd1536;
   localparam logic [63:0] ET7  = ET6 / 64'd1792;
   localparam logic [63:0] ET8  = ET7 / 64'd2048;
   localparam logic [63:0] ET9  = ET8 / 64'd2304;
   localparam logic [63:0] ET10 = ET9 / 64'd2560;

   function automatic logic [63:0] mul60c(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return p[123:60];
   endfunction

   localparam logic [63:0] EB0  = ONE60 - ET1 + ET2 - ET3 + ET4 - ET5 + ET6 - ET7
                                  + ET8 - ET9 + ET10;
   localparam logic [63:0] EB1  = mul60c(EB0, EB0);
   localparam logic [63:0] EB2  = mul60c(EB1, EB1);
   localparam logic [63:0] EB3  = mul60c(EB2, EB2);
   localparam logic [63:0] EB4  = mul60c(EB3, EB3);
   localparam logic [63:0] EB5  = mul60c(EB4, EB4);
   localparam logic [63:0] EB6  = mul60c(EB5, EB5);
   localparam logic [63:0] EB7  = mul60c(EB6, EB6);
   localparam logic [63:0] EB8  = mul60c(EB7, EB7);
   localparam logic [63:0] EB9  = mul60c(EB8, EB8);
   localparam logic [63:0] EB10 = mul60c(EB9, EB9);

   localparam int unsigned EXP_STEPS = 11;

   localparam logic [60:0] EXP_BASE [EXP_STEPS] = '{
      EB0[60:0], EB1[60:0], EB2[60:0], EB3[60:0], EB4[60:0], EB5[60:0],
      EB6[60:0], EB7[60:0], EB8[60:0], EB9[60:0], EB10[60:0]
   };

   function automatic logic signed [DATA_W-1:0] sat16(input logic signed [39:0] v);
      if (v > 40'sd32767) begin
         return 16'sh7fff;
      end else if (v < -40'sd32768) begin
         return 16'sh8000;
      end else begin
         return v[DATA_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

/* rtl/core/bna_front.sv */
// ----------------------------------------------------------------------------
// bna_front
// Accepts items, tags samples with channel and row end, feeds the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bna_front #(
   parameter int unsigned CHANNELS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_op,
   input  logic [5:0]            req_param_channel,
   input  logic signed [15:0]    req_channel_mean,
   input  logic [15:0]           req_channel_variance,
   input  logic signed [15:0]    req_channel_gamma,
   input  logic signed [15:0]    req_channel_beta,
   input  logic signed [15:0]    req_sample_value,
   input  logic [6:0]            channels_in_use,
   input  logic                  q_full,
   output logic                  push,
   output bna_pkg::item_type     push_item,
   output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] push_chan
);
   import bna_pkg::*;

   localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int unsigned CW    = (IDX_W + 2 > 8) ? IDX_W + 2 : 8;

   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [CW-1:0]    ciu_ext, n_eff, next_ext;
   logic             row_end, accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign push      = accept;

   assign ciu_ext  = CW'(channels_in_use);
   assign n_eff    = (ciu_ext == '0 || ciu_ext > CW'(CHANNELS)) ? CW'(CHANNELS) : ciu_ext;
   assign next_ext = CW'(cnt_ff) + CW'(1);
   assign row_end  = (next_ext >= n_eff);

   always_comb begin
      cnt_in = cnt_ff;
      if (accept) begin
         if (op_type'(req_op) == OP_LOAD || row_end) begin
            cnt_in = '0;
         end else begin
            cnt_in = next_ext[IDX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_comb begin
      push_item.op               = op_type'(req_op);
      push_item.param_channel    = req_param_channel;
      push_item.channel_mean     = req_channel_mean;
      push_item.channel_variance = req_channel_variance;
      push_item.channel_gamma    = req_channel_gamma;
      push_item.channel_beta     = req_channel_beta;
      push_item.sample_value     = req_sample_value;
      push_item.row_end          = row_end;
   end

   assign push_chan = cnt_ff;

endmodule

`default_nettype wire

/* rtl/core/bna_queue.sv */
// ----------------------------------------------------------------------------
// bna_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module bna_queue #(
   parameter int unsigned WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);
   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/bna_act.sv */
// ----------------------------------------------------------------------------
// bna_act
// Iterative tanh / sigmoid unit: exp by repeated squaring, then a divider.
// ----------------------------------------------------------------------------
`default_nettype none

module bna_act (
   input  logic                 clock,
   input  logic                 reset,
   input  bna_pkg::act_req_type act_req,
   output bna_pkg::act_rsp_type act_rsp
);
   import bna_pkg::*;

   typedef enum logic [5:0] {
      A_IDLE = 6'b000001,
      A_EXP  = 6'b000010,
      A_MUL  = 6'b000100,
      A_PREP = 6'b001000,
      A_DIV  = 6'b010000,
      A_DONE = 6'b100000
   } act_state_type;

   act_state_type state_ff, state_in;

   logic                sig_ff, neg_ff;
   logic [10:0]         m_ff;
   logic [3:0]          j_ff;
   logic [2:0]          k_ff;
   logic [60:0]         res_ff;
   logic [61:0]         pp_ff;
   logic [1:0]          psh_ff;
   logic [121:0]        acc_ff;
   logic [60:0]         n_ff, ds_ff;
   logic [8:0]          q_ff;
   logic [3:0]          b_ff;

   logic signed [16:0]  v17;
   logic [16:0]         mag;
   logic                sat;
   logic [60:0]         base;
   logic [30:0]         ma, mb;
   logic [1:0]          psh_new;
   logic [121:0]        pp_shift, acc_sum;
   logic [50:0]         e;
   logic [60:0]         n_new, d_new;
   logic                ge;
   logic [8:0]          r_val;

   assign v17 = {act_req.value[15], act_req.value};
   assign mag = v17[16] ? 17'(-v17) : 17'(v17);
   assign sat = act_req.sigmoid ? (mag >= 17'd2048) : (mag >= 17'd1024);

   assign base = (j_ff < 4'(EXP_STEPS)) ? EXP_BASE[j_ff] : '0;

   always_comb begin
      unique case (k_ff)
         3'd0: begin
            ma = res_ff[30:0];
            mb = base[30:0];
            psh_new = 2'd0;
         end
         3'd1: begin
            ma = {1'b0, res_ff[60:31]};
            mb = base[30:0];
            psh_new = 2'd1;
         end
         3'd2: begin
            ma = res_ff[30:0];
            mb = {1'b0, base[60:31]};
            psh_new = 2'd1;
         end
         3'd3: begin
            ma = {1'b0, res_ff[60:31]};
            mb = {1'b0, base[60:31]};
            psh_new = 2'd2;
         end
         default: begin
            ma = '0;
            mb = '0;
            psh_new = 2'd0;
         end
      endcase
   end

   always_comb begin
      unique case (psh_ff)
         2'd0:    pp_shift = 122'(pp_ff);
         2'd1:    pp_shift = 122'(pp_ff) << 31;
         2'd2:    pp_shift = 122'(pp_ff) << 62;
         default: pp_shift = '0;
      endcase
   end

   assign acc_sum = acc_ff + pp_shift;

   assign e     = res_ff[60:10];
   assign d_new = (61'(e) + (61'd1 << 50)) << 9;
   assign n_new = sig_ff ? ((61'd513 << 50) + 61'(e))
                         : ((61'd513 << 50) - ((61'(e) << 9) - 61'(e)));
   assign ge    = (n_ff >= ds_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         A_IDLE: begin
            if (act_req.start) begin
               state_in = sat ? A_DONE : A_EXP;
            end
         end
         A_EXP: begin
            if (j_ff == 4'(EXP_STEPS)) begin
               state_in = A_PREP;
            end else if (m_ff[j_ff]) begin
               state_in = A_MUL;
            end
         end
         A_MUL: begin
            if (k_ff == 3'd4) begin
               state_in = A_EXP;
            end
         end
         A_PREP:  state_in = A_DIV;
         A_DIV: begin
            if (b_ff == 4'd0) begin
               state_in = A_DONE;
            end
         end
         A_DONE:  state_in = A_IDLE;
         default: state_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         A_IDLE: begin
            sig_ff <= act_req.sigmoid;
            neg_ff <= v17[16];
            m_ff   <= act_req.sigmoid ? mag[10:0] : {mag[9:0], 1'b0};
            j_ff   <= 4'd0;
            res_ff <= 61'd1 << 60;
            q_ff   <= 9'd256;
         end
         A_EXP: begin
            k_ff   <= 3'd0;
            acc_ff <= '0;
            if (j_ff != 4'(EXP_STEPS) && !m_ff[j_ff]) begin
               j_ff <= j_ff + 4'd1;
            end
         end
         A_MUL: begin
            if (k_ff != 3'd4) begin
               pp_ff  <= 62'(ma) * 62'(mb);
               psh_ff <= psh_new;
               k_ff   <= k_ff + 3'd1;
            end
            if (k_ff != 3'd0) begin
               acc_ff <= acc_sum;
            end
            if (k_ff == 3'd4) begin
               res_ff <= acc_sum[120:60];
               j_ff   <= j_ff + 4'd1;
            end
         end
         A_PREP: begin
            n_ff  <= n_new;
            ds_ff <= d_new;
            q_ff  <= '0;
            b_ff  <= 4'd8;
         end
         A_DIV: begin
            if (ge) begin
               n_ff <= n_ff - ds_ff;
            end
            ds_ff <= ds_ff >> 1;
            q_ff  <= {q_ff[7:0], ge};
            b_ff  <= b_ff - 4'd1;
         end
         A_DONE: begin
         end
         default: begin
         end
      endcase
   end

   assign r_val = sig_ff ? (neg_ff ? 9'd256 - q_ff : q_ff) : q_ff;

   always_comb begin
      act_rsp.done = (state_ff == A_DONE);
      if (!sig_ff && neg_ff) begin
         act_rsp.value = -$signed(16'(r_val));
      end else begin
         act_rsp.value = $signed(16'(r_val));
      end
   end

endmodule

`default_nettype wire

/* rtl/core/bna_back.sv */
// ----------------------------------------------------------------------------
// bna_back
// Executes queued items: parameter loads into the tables and sample math.
// ----------------------------------------------------------------------------
`default_nettype none

module bna_back #(
   parameter int unsigned CHANNELS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  bna_pkg::item_type     q_item,
   input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] q_chan,
   input  logic [1:0]            activation_mode,
   output bna_pkg::act_req_type  act_req,
   input  bna_pkg::act_rsp_type  act_rsp,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [15:0]    rsp_result_value,
   output logic [5:0]            rsp_result_channel,
   output logic                  rsp_row_end
);
   import bna_pkg::*;

   localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int unsigned CW    = (IDX_W + 2 > 8) ? IDX_W + 2 : 8;

   typedef enum logic [12:0] {
      S_IDLE = 13'b0000000000001,
      S_LSQ  = 13'b0000000000010,
      S_TRA  = 13'b0000000000100,
      S_TRB  = 13'b0000000001000,
      S_SC   = 13'b0000000010000,
      S_MS   = 13'b0000000100000,
      S_WR   = 13'b0000001000000,
      S_RD   = 13'b0000010000000,
      S_MUL  = 13'b0000100000000,
      S_ADD  = 13'b0001000000000,
      S_ACT  = 13'b0010000000000,
      S_WAIT = 13'b0100000000000,
      S_OUT  = 13'b1000000000000
   } back_state_type;

   back_state_type state_ff, state_in;

   logic signed [15:0] scale_mem [CHANNELS];
   logic signed [15:0] shift_mem [CHANNELS];

   item_type            cur_ff;
   logic [IDX_W-1:0]    chan_ff;
   logic [30:0]         gsq_ff;
   logic [15:0]         x_ff, t_ff;
   logic                tok_ff;
   logic [3:0]          bit_ff;
   logic [31:0]         dd_ff;
   logic signed [15:0]  sc_ff;
   logic signed [31:0]  mprod_ff;
   logic signed [15:0]  sc_rd_ff, sh_rd_ff;
   logic signed [31:0]  sprod_ff;
   logic signed [15:0]  pre_ff, fin_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]  val_ff;
   logic [5:0]          chn_ff;
   logic                re_ff;

   logic signed [16:0]  g17;
   logic [16:0]         gm;
   logic [15:0]         trial, dval;
   logic [16:0]         v17;
   logic [48:0]         prod49;
   logic [40:0]         big;
   logic                fits;
   logic signed [39:0]  wr_sum, pre_sum;
   logic [CW-1:0]       pch_ext, chan_ext;
   logic                in_range, out_load;
   act_mode_type        mode;

   assign mode = act_mode_type'(activation_mode);

   assign g17    = {cur_ff.channel_gamma[15], cur_ff.channel_gamma};
   assign gm     = g17[16] ? 17'(-g17) : 17'(g17);
   assign trial  = x_ff | (16'd1 << bit_ff);
   assign dval   = {trial[14:0], 1'b0} - 16'd1;
   assign v17    = 17'(cur_ff.channel_variance) + 17'd1;
   assign prod49 = 49'(dd_ff) * 49'(v17);
   assign big    = {gsq_ff[30:0], 10'b0};
   assign fits   = tok_ff && (prod49 <= 49'(big));

   assign wr_sum  = (40'(cur_ff.channel_beta) <<< 8) - 40'(mprod_ff) + 40'sd128;
   assign pre_sum = 40'(sprod_ff) + (40'(sh_rd_ff) <<< 8) + 40'sd128;

   assign pch_ext  = CW'(cur_ff.param_channel);
   assign in_range = (pch_ext < CW'(CHANNELS));
   assign chan_ext = CW'(chan_ff);

   assign q_pop    = (state_ff == S_IDLE) && q_valid;
   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               state_in = (q_item.op == OP_LOAD) ? S_LSQ : S_RD;
            end
         end
         S_LSQ:  state_in = S_TRA;
         S_TRA:  state_in = S_TRB;
         S_TRB:  state_in = (bit_ff == 4'd0) ? S_SC : S_TRA;
         S_SC:   state_in = S_MS;
         S_MS:   state_in = S_WR;
         S_WR:   state_in = S_IDLE;
         S_RD:   state_in = S_MUL;
         S_MUL:  state_in = S_ADD;
         S_ADD:  state_in = S_ACT;
         S_ACT: begin
            if (mode == ACT_TANH || mode == ACT_SIGMOID) begin
               state_in = S_WAIT;
            end else begin
               state_in = S_OUT;
            end
         end
         S_WAIT: begin
            if (act_rsp.done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            cur_ff  <= q_item;
            chan_ff <= q_chan;
         end
         S_LSQ: begin
            gsq_ff <= 31'(gm) * 31'(gm);
            x_ff   <= '0;
            bit_ff <= 4'd15;
         end
         S_TRA: begin
            dd_ff  <= 32'(dval) * 32'(dval);
            t_ff   <= trial;
            tok_ff <= (trial <= 16'd32768);
         end
         S_TRB: begin
            if (fits) begin
               x_ff <= t_ff;
            end
            bit_ff <= bit_ff - 4'd1;
         end
         S_SC: begin
            if (g17[16]) begin
               sc_ff <= $signed(16'(-x_ff));
            end else begin
               sc_ff <= (x_ff > 16'd32767) ? 16'sh7fff : $signed(x_ff);
            end
         end
         S_MS: begin
            mprod_ff <= cur_ff.channel_mean * sc_ff;
         end
         S_WR: begin
         end
         S_RD: begin
            sc_rd_ff <= scale_mem[chan_ff];
            sh_rd_ff <= shift_mem[chan_ff];
         end
         S_MUL: begin
            sprod_ff <= cur_ff.sample_value * sc_rd_ff;
         end
         S_ADD: begin
            pre_ff <= sat16(pre_sum >>> 8);
         end
         S_ACT: begin
            fin_ff <= (mode == ACT_RELU && pre_ff[15]) ? 16'sd0 : pre_ff;
         end
         S_WAIT: begin
            if (act_rsp.done) begin
               fin_ff <= act_rsp.value;
            end
         end
         S_OUT: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_WR && in_range) begin
         scale_mem[pch_ext[IDX_W-1:0]] <= sc_ff;
         shift_mem[pch_ext[IDX_W-1:0]] <= sat16(wr_sum >>> 8);
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         val_ff <= fin_ff;
         chn_ff <= chan_ext[5:0];
         re_ff  <= cur_ff.row_end;
      end
   end

   always_comb begin
      act_req.start   = (state_ff == S_ACT) && (mode == ACT_TANH || mode == ACT_SIGMOID);
      act_req.sigmoid = (mode == ACT_SIGMOID);
      act_req.value   = pre_ff;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_value   = val_ff;
   assign rsp_result_channel = chn_ff;
   assign rsp_row_end        = re_ff;

endmodule

`default_nettype wire

/* rtl/core/batchnorm_activation_inference.sv */
// ----------------------------------------------------------------------------
// batchnorm_activation_inference
// Batch-norm inference with fused none / relu / tanh / sigmoid activation.
// ----------------------------------------------------------------------------
// sample: read, multiply, add and activate states; tanh or sigmoid also wait on bna_act
//   (exp by up to 11 serial 61-bit multiplies, then a 9-step divide)
// load: a 16-step scale search with a trial and a check state per bit, then the table write
// one item at a time in the back; a two-entry queue lets the front keep taking items until it is full
// reset: synchronous; clears control, counter and config; tables hold junk
`default_nettype none

module batchnorm_activation_inference #(
   parameter int unsigned CHANNELS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_op,
   input  logic [5:0]         req_param_channel,
   input  logic signed [15:0] req_channel_mean,
   input  logic [15:0]        req_channel_variance,
   input  logic signed [15:0] req_channel_gamma,
   input  logic signed [15:0] req_channel_beta,
   input  logic signed [15:0] req_sample_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_result_value,
   output logic [5:0]         rsp_result_channel,
   output logic               rsp_row_end,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import bna_pkg::*;

   localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int unsigned Q_W   = $bits(item_type) + IDX_W;

   logic [CIU_W-1:0]  ciu_ff, ciu_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic              cfg_wr;
   reg_index_type     reg_sel;

   logic              push, q_full, q_pop, q_valid;
   item_type          push_item, q_item;
   logic [IDX_W-1:0]  push_chan, q_chan;
   logic [Q_W-1:0]    q_data;
   act_req_type       act_req;
   act_rsp_type       act_rsp;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = reg_index_type'(csr_paddr[2]);

   always_comb begin
      ciu_in  = ciu_ff;
      mode_in = mode_ff;
      if (cfg_wr) begin
         unique case (reg_sel)
            REG_CIU:  ciu_in  = csr_pwdata[CIU_W-1:0];
            REG_MODE: mode_in = csr_pwdata[MODE_W-1:0];
            default:  ciu_in  = ciu_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ciu_ff  <= CIU_RESET;
         mode_ff <= ACT_NONE;
      end else begin
         ciu_ff  <= ciu_in;
         mode_ff <= mode_in;
      end
   end

   assign csr_prdata = (reg_sel == REG_MODE) ? 32'(mode_ff) : 32'(ciu_ff);

   bna_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_op               (req_op),
      .req_param_channel    (req_param_channel),
      .req_channel_mean     (req_channel_mean),
      .req_channel_variance (req_channel_variance),
      .req_channel_gamma    (req_channel_gamma),
      .req_channel_beta     (req_channel_beta),
      .req_sample_value     (req_sample_value),
      .channels_in_use      (ciu_ff),
      .q_full               (q_full),
      .push                 (push),
      .push_item            (push_item),
      .push_chan            (push_chan)
   );

   bna_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_item, push_chan}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .not_empty (q_valid)
   );

   assign q_item = item_type'(q_data[Q_W-1:IDX_W]);
   assign q_chan = q_data[IDX_W-1:0];

   bna_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_pop              (q_pop),
      .q_item             (q_item),
      .q_chan             (q_chan),
      .activation_mode    (mode_ff),
      .act_req            (act_req),
      .act_rsp            (act_rsp),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_value   (rsp_result_value),
      .rsp_result_channel (rsp_result_channel),
      .rsp_row_end        (rsp_row_end)
   );

   bna_act u_act (
      .clock   (clock),
      .reset   (reset),
      .act_req (act_req),
      .act_rsp (act_rsp)
   );

endmodule

`default_nettype wire

/* rtl/core/bna_check.sv */
// ----------------------------------------------------------------------------
// bna_check
// Port-level checks on the batch-norm block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bna_check (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_result_value,
   input logic [5:0]         rsp_result_channel,
   input logic               rsp_row_end,
   input logic               csr_pready
);

   // a stalled transfer holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_value)
         && $stable(rsp_result_channel) && $stable(rsp_row_end))
      else $error("rsp payload changed while stalled");

   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_req_reset: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("req stalled with empty queue after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("csr pready low");

endmodule

bind batchnorm_activation_inference bna_check u_check (.*);

`default_nettype wire
